/* rtl/frc_pkg.sv */
// Shared types and constants for the frame reassembly checker.
package frc_pkg;

    localparam int unsigned MAX_MESSAGE_BYTES = 496;
    localparam int unsigned LEN_W             = 9;
    localparam int unsigned SEQ_W             = 16;
    localparam int unsigned SIZE_W            = 24;
    localparam int unsigned COUNT_W           = 26;
    localparam int unsigned FRAME_NUM_W       = 32;
    localparam int unsigned QUEUE_DEPTH       = 4;
    localparam int unsigned QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    // message kinds
    localparam logic [1:0] KIND_CAPTURE = 2'd2;

    // section codes
    localparam logic [2:0] SEC_NONE  = 3'd0;
    localparam logic [2:0] SEC_START = 3'd1;
    localparam logic [2:0] SEC_BODY  = 3'd2;
    localparam logic [2:0] SEC_END   = 3'd3;

    // result status codes
    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_STORED   = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_READERR  = 3'd3;
    localparam logic [2:0] ST_FRAMEERR = 3'd4;
    localparam logic [2:0] ST_SYNCERR  = 3'd5;

    typedef struct packed {
        logic             read_failed;
        logic [1:0]       message_kind;
        logic [2:0]       section;
        logic [SEQ_W-1:0] message_seq;
        logic [LEN_W-1:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [2:0]             status;
        logic [SIZE_W-1:0]      write_offset;
        logic [FRAME_NUM_W-1:0] frame_number;
    } t_out_item;

    typedef enum logic [2:0] {
        CLS_IGNORE,
        CLS_READERR,
        CLS_START,
        CLS_BODY,
        CLS_END,
        CLS_INVALID
    } t_cls;

    // classified header handed from front to back
    typedef struct packed {
        t_cls             cls;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

/* rtl/frc_front.sv */
// Front end: classifies a message header and clamps its payload length.
module frc_front (
    input  frc_pkg::t_in_item i_item,
    output frc_pkg::t_cmd     o_cmd
);

    frc_pkg::t_cls           cls;
    logic [frc_pkg::LEN_W-1:0] len;

    always_comb begin
        if (i_item.read_failed) begin
            cls = frc_pkg::CLS_READERR;
        end else if (i_item.message_kind != frc_pkg::KIND_CAPTURE) begin
            cls = frc_pkg::CLS_IGNORE;
        end else begin
            case (i_item.section)
                frc_pkg::SEC_NONE:  cls = frc_pkg::CLS_IGNORE;
                frc_pkg::SEC_START: cls = frc_pkg::CLS_START;
                frc_pkg::SEC_BODY:  cls = frc_pkg::CLS_BODY;
                frc_pkg::SEC_END:   cls = frc_pkg::CLS_END;
                default:            cls = frc_pkg::CLS_INVALID;
            endcase
        end
    end

    assign len = (i_item.payload_length > frc_pkg::LEN_W'(frc_pkg::MAX_MESSAGE_BYTES))
               ? frc_pkg::LEN_W'(frc_pkg::MAX_MESSAGE_BYTES)
               : i_item.payload_length;

    assign o_cmd = '{cls: cls, seq: i_item.message_seq, len: len};

endmodule

/* rtl/frc_queue.sv */
// Small command queue between the classifier and the frame tracker.
module frc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  frc_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    output logic          o_valid,
    output frc_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    frc_pkg::t_cmd                 r_mem [frc_pkg::QUEUE_DEPTH];
    logic [frc_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [frc_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [frc_pkg::QCNT_W-1:0]    r_count,  n_count;
    logic                          do_pop;

    assign o_full  = (r_count == frc_pkg::QCNT_W'(frc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + frc_pkg::QCNT_W'(i_push) - frc_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    ap_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= frc_pkg::QCNT_W'(frc_pkg::QUEUE_DEPTH))
        else $error("queue count past depth");

    ap_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    ap_push_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push lost");

endmodule

/* rtl/frc_back.sv */
// Back end: frame tracking state, frame size register and result register.
module frc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [frc_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  logic                          i_q_valid,
    input  frc_pkg::t_cmd                 i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output frc_pkg::t_out_item            o_out_item
);

    typedef enum logic {
        MODE_HUNT,
        MODE_FRAME
    } t_mode;

    t_mode                              r_mode, n_mode;
    logic [frc_pkg::SEQ_W-1:0]          r_exp_seq, n_exp_seq;
    logic [frc_pkg::COUNT_W-1:0]        r_byte_count, n_byte_count;
    logic [frc_pkg::FRAME_NUM_W-1:0]    r_frames_done, n_frames_done;
    logic [frc_pkg::SIZE_W-1:0]         r_frame_bytes;
    logic                               r_out_valid;
    frc_pkg::t_out_item                 r_out_item, n_out_item;

    logic                               pop;
    logic [frc_pkg::COUNT_W-1:0]        size_ext;
    logic [frc_pkg::COUNT_W-1:0]        len_ext;
    logic [frc_pkg::COUNT_W-1:0]        hunt_sum;
    logic [frc_pkg::COUNT_W-1:0]        base;
    logic [frc_pkg::COUNT_W-1:0]        frame_sum;
    logic [frc_pkg::SEQ_W-1:0]          base_seq;
    logic                               is_start;

    assign pop      = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop  = pop;
    assign size_ext = frc_pkg::COUNT_W'(r_frame_bytes);
    assign len_ext  = frc_pkg::COUNT_W'(i_q_cmd.len);
    assign hunt_sum = r_byte_count + len_ext;
    assign is_start = (i_q_cmd.cls == frc_pkg::CLS_START);
    // a start inside a frame rebases the frame at offset 0
    assign base      = is_start ? '0 : r_byte_count;
    assign base_seq  = is_start ? '0 : r_exp_seq;
    assign frame_sum = base + len_ext;

    always_comb begin
        n_mode        = r_mode;
        n_exp_seq     = r_exp_seq;
        n_byte_count  = r_byte_count;
        n_frames_done = r_frames_done;
        n_out_item    = '{status: frc_pkg::ST_IGNORED, write_offset: '0, frame_number: '0};

        case (i_q_cmd.cls)
            frc_pkg::CLS_IGNORE: begin
            end
            frc_pkg::CLS_READERR: begin
                n_mode            = MODE_HUNT;
                n_exp_seq         = '0;
                n_byte_count      = '0;
                n_out_item.status = frc_pkg::ST_READERR;
            end
            frc_pkg::CLS_INVALID: begin
                if (r_mode == MODE_FRAME) begin
                    n_mode            = MODE_HUNT;
                    n_exp_seq         = '0;
                    n_byte_count      = '0;
                    n_out_item.status = frc_pkg::ST_FRAMEERR;
                end
            end
            frc_pkg::CLS_START, frc_pkg::CLS_BODY, frc_pkg::CLS_END: begin
                if (r_mode == MODE_HUNT) begin
                    if (is_start && i_q_cmd.seq == '0) begin
                        if (len_ext > size_ext) begin
                            n_byte_count      = '0;
                            n_out_item.status = frc_pkg::ST_FRAMEERR;
                        end else begin
                            n_mode            = MODE_FRAME;
                            n_byte_count      = len_ext;
                            n_exp_seq         = frc_pkg::SEQ_W'(1);
                            n_out_item.status = frc_pkg::ST_STORED;
                        end
                    end else if (hunt_sum > {size_ext[frc_pkg::COUNT_W-2:0], 1'b0}) begin
                        // skipped too much capture data without finding a start
                        n_byte_count      = '0;
                        n_out_item.status = frc_pkg::ST_SYNCERR;
                    end else begin
                        n_byte_count = hunt_sum;
                    end
                end else if (i_q_cmd.seq != r_exp_seq) begin
                    n_mode            = MODE_HUNT;
                    n_exp_seq         = '0;
                    n_byte_count      = '0;
                    n_out_item.status = frc_pkg::ST_SYNCERR;
                end else if (frame_sum > size_ext ||
                             (i_q_cmd.cls == frc_pkg::CLS_END && frame_sum < size_ext)) begin
                    n_mode            = MODE_HUNT;
                    n_exp_seq         = '0;
                    n_byte_count      = '0;
                    n_out_item.status = frc_pkg::ST_FRAMEERR;
                end else if (i_q_cmd.cls == frc_pkg::CLS_END) begin
                    n_mode        = MODE_HUNT;
                    n_exp_seq     = '0;
                    n_byte_count  = '0;
                    n_frames_done = r_frames_done + 1'b1;
                    n_out_item    = '{status:       frc_pkg::ST_COMPLETE,
                                      write_offset: base[frc_pkg::SIZE_W-1:0],
                                      frame_number: r_frames_done};
                end else begin
                    n_byte_count            = frame_sum;
                    n_exp_seq               = base_seq + 1'b1;
                    n_out_item.status       = frc_pkg::ST_STORED;
                    n_out_item.write_offset = base[frc_pkg::SIZE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_HUNT;
            r_exp_seq     <= '0;
            r_byte_count  <= '0;
            r_frames_done <= '0;
            r_frame_bytes <= '0;
            r_out_valid   <= 1'b0;
            r_out_item    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_frame_bytes <= i_cfg_wdata;
            end
            if (pop) begin
                r_mode        <= n_mode;
                r_exp_seq     <= n_exp_seq;
                r_byte_count  <= n_byte_count;
                r_frames_done <= n_frames_done;
                r_out_valid   <= 1'b1;
                r_out_item    <= n_out_item;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ap_hunt_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HUNT) |-> (r_exp_seq == '0))
        else $error("expected sequence not cleared while hunting");

    ap_frame_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && n_mode == MODE_FRAME && n_out_item.status == frc_pkg::ST_STORED) |=>
            (r_byte_count <= size_ext))
        else $error("frame byte count past frame size");

    ap_frames_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_frames_done != $past(r_frames_done)) |->
            (r_out_valid && r_out_item.status == frc_pkg::ST_COMPLETE))
        else $error("frame counter moved without a completed frame");

    ap_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status != frc_pkg::ST_COMPLETE) |->
            (r_out_item.frame_number == '0))
        else $error("frame number set on a result that is not a completion");

endmodule

/* rtl/frame_reassembly_checker_top.sv */
// Top level of the frame reassembly checker: classifier, command queue, frame tracker.
// An accepted header is classified, written into the command queue, and its result is registered once popped.
// Throughput: one header per cycle while the queue is not full; the tracker pops unless the result is stalled.
// A four-entry command queue lets the input side keep taking transfers while a result waits.
// Reset (i_rst_n low, synchronous): hunting state, frame size 0, frame counter 0, queue empty.
// Configuration takes effect on the cycle after the write; no clearing pass is needed.
module frame_reassembly_checker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [frc_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  frc_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output frc_pkg::t_out_item            o_out_item
);

    frc_pkg::t_cmd front_cmd;
    frc_pkg::t_cmd q_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          push;

    assign push       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    frc_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    frc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (front_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    frc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* sim/frame_reassembly_checker_top_tb.sv */
// Self-checking testbench for frame_reassembly_checker_top: random frames, noise and back-pressure.
module frame_reassembly_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned IN_W        = $bits(frc_pkg::t_in_item);
    localparam int unsigned LONG_HOLD   = 300;

    localparam logic [1:0] KIND_INFO      = 2'd0;
    localparam logic [1:0] KIND_LOG       = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN   = 2'd3;
    localparam logic [2:0] SEC_INVALID_LO = 3'd4;
    localparam logic [2:0] SEC_INVALID_HI = 3'd7;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [frc_pkg::SIZE_W-1:0]       i_cfg_wdata = '0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_stall;
    frc_pkg::t_in_item                i_in_item   = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    frc_pkg::t_out_item               o_out_item;

    // predictor state
    logic [frc_pkg::SIZE_W-1:0]       cfg_size        = '0;
    logic                             trk_in_frame    = 1'b0;
    logic [frc_pkg::SEQ_W-1:0]        trk_exp_seq     = '0;
    logic [frc_pkg::COUNT_W-1:0]      trk_byte_cnt    = '0;
    logic [frc_pkg::FRAME_NUM_W-1:0]  trk_frames_done = '0;

    frc_pkg::t_in_item                headers_to_send[$];
    frc_pkg::t_out_item               results_due[$];
    frc_pkg::t_out_item               want;
    int unsigned                      mismatches   = 0;
    int unsigned                      results_seen = 0;
    int unsigned                      cycles       = 0;
    int unsigned                      hold_left    = 0;
    bit                               hold_done    = 1'b0;
    bit                               quiet        = 1'b0;

    frame_reassembly_checker_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void restart_hunt();
        trk_in_frame = 1'b0;
        trk_exp_seq  = '0;
        trk_byte_cnt = '0;
    endfunction

    // Advances the frame tracker by one header and returns the result it must produce.
    function automatic frc_pkg::t_out_item frame_track(frc_pkg::t_in_item h);
        frc_pkg::t_out_item          r;
        logic [frc_pkg::LEN_W-1:0]   len;
        logic [frc_pkg::COUNT_W:0]   sum;
        logic [frc_pkg::SIZE_W-1:0]  off;
        r   = '0;
        len = (h.payload_length > frc_pkg::MAX_MESSAGE_BYTES)
            ? frc_pkg::LEN_W'(frc_pkg::MAX_MESSAGE_BYTES) : h.payload_length;
        if (h.read_failed) begin
            restart_hunt();
            r.status = frc_pkg::ST_READERR;
        end else if (h.message_kind != frc_pkg::KIND_CAPTURE ||
                     h.section == frc_pkg::SEC_NONE) begin
            r.status = frc_pkg::ST_IGNORED;
        end else if (!trk_in_frame) begin
            if (h.section > frc_pkg::SEC_END) begin
                r.status = frc_pkg::ST_IGNORED;
            end else if (h.section == frc_pkg::SEC_START && h.message_seq == '0) begin
                if (len > cfg_size) begin
                    restart_hunt();
                    r.status = frc_pkg::ST_FRAMEERR;
                end else begin
                    trk_in_frame = 1'b1;
                    trk_byte_cnt = frc_pkg::COUNT_W'(len);
                    trk_exp_seq  = frc_pkg::SEQ_W'(1);
                    r.status     = frc_pkg::ST_STORED;
                end
            end else begin
                // skipped capture bytes while hunting
                trk_byte_cnt = trk_byte_cnt + frc_pkg::COUNT_W'(len);
                if ({1'b0, trk_byte_cnt} > {2'b00, cfg_size, 1'b0}) begin
                    restart_hunt();
                    r.status = frc_pkg::ST_SYNCERR;
                end else begin
                    r.status = frc_pkg::ST_IGNORED;
                end
            end
        end else if (h.section > frc_pkg::SEC_END) begin
            restart_hunt();
            r.status = frc_pkg::ST_FRAMEERR;
        end else if (h.message_seq != trk_exp_seq) begin
            restart_hunt();
            r.status = frc_pkg::ST_SYNCERR;
        end else begin
            if (h.section == frc_pkg::SEC_START) begin
                trk_byte_cnt = '0;
                trk_exp_seq  = '0;
            end
            sum = {1'b0, trk_byte_cnt} + (frc_pkg::COUNT_W + 1)'(len);
            if (sum > (frc_pkg::COUNT_W + 1)'(cfg_size)) begin
                restart_hunt();
                r.status = frc_pkg::ST_FRAMEERR;
            end else begin
                off          = trk_byte_cnt[frc_pkg::SIZE_W-1:0];
                trk_byte_cnt = sum[frc_pkg::COUNT_W-1:0];
                trk_exp_seq  = trk_exp_seq + frc_pkg::SEQ_W'(1);
                if (h.section == frc_pkg::SEC_END) begin
                    if (trk_byte_cnt < frc_pkg::COUNT_W'(cfg_size)) begin
                        restart_hunt();
                        r.status = frc_pkg::ST_FRAMEERR;
                    end else begin
                        r.status        = frc_pkg::ST_COMPLETE;
                        r.write_offset  = off;
                        r.frame_number  = trk_frames_done;
                        trk_frames_done = trk_frames_done + 1'b1;
                        restart_hunt();
                    end
                end else begin
                    r.status       = frc_pkg::ST_STORED;
                    r.write_offset = off;
                end
            end
        end
        return r;
    endfunction

    // sender: holds a stalled transfer, otherwise offers the next header or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                results_due.push_back(frame_track(i_in_item));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (headers_to_send.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
                    i_in_item  <= headers_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off once traffic is flowing
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && results_seen >= 150) begin
            hold_done   <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (results_due.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: unexpected result status %0d offset %0d frame %0d",
                             o_out_item.status, o_out_item.write_offset,
                             o_out_item.frame_number);
                mismatches = mismatches + 1;
            end else begin
                want = results_due.pop_front();
                if (want.status != o_out_item.status ||
                    want.write_offset != o_out_item.write_offset ||
                    want.frame_number != o_out_item.frame_number) begin
                    if (mismatches < 10)
                        $display("ERROR: result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 results_seen, want.status, want.write_offset,
                                 want.frame_number, o_out_item.status,
                                 o_out_item.write_offset, o_out_item.frame_number);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic frc_pkg::t_in_item capture_hdr(logic [2:0] sec,
                                                      logic [frc_pkg::SEQ_W-1:0] seq,
                                                      logic [frc_pkg::LEN_W-1:0] len);
        frc_pkg::t_in_item h;
        h                = '0;
        h.message_kind   = frc_pkg::KIND_CAPTURE;
        h.section        = sec;
        h.message_seq    = seq;
        h.payload_length = len;
        return h;
    endfunction

    // a full-size payload is sometimes sent with a length field at or above the maximum, which saturates
    function automatic logic [frc_pkg::LEN_W-1:0] len_field(int unsigned l);
        if (l == frc_pkg::MAX_MESSAGE_BYTES && $urandom_range(0, 1) == 1)
            return frc_pkg::LEN_W'($urandom_range(frc_pkg::MAX_MESSAGE_BYTES, 511));
        return frc_pkg::LEN_W'(l);
    endfunction

    task automatic write_frame_size(input logic [frc_pkg::SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        cfg_size    <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (headers_to_send.size() != 0 || i_in_valid || results_due.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // One frame split into sections, sometimes with a single flaw.
    task automatic queue_frame(input int unsigned size);
        frc_pkg::t_in_item secs[$];
        frc_pkg::t_in_item prefix[$];
        frc_pkg::t_in_item h;
        int unsigned       rem, l, seq, pos, k, n;
        rem = (size > 4000) ? $urandom_range(0, 3000) : size;
        l   = $urandom_range(0, rem < frc_pkg::MAX_MESSAGE_BYTES
                                ? rem : frc_pkg::MAX_MESSAGE_BYTES);
        secs.push_back(capture_hdr(frc_pkg::SEC_START, '0, len_field(l)));
        rem = rem - l;
        seq = 1;
        while (rem > frc_pkg::MAX_MESSAGE_BYTES || (rem > 0 && $urandom_range(0, 3) == 0)) begin
            l = $urandom_range(rem > frc_pkg::MAX_MESSAGE_BYTES ? 1 : 0,
                               rem < frc_pkg::MAX_MESSAGE_BYTES
                               ? rem : frc_pkg::MAX_MESSAGE_BYTES);
            secs.push_back(capture_hdr(frc_pkg::SEC_BODY, frc_pkg::SEQ_W'(seq), len_field(l)));
            rem = rem - l;
            seq = seq + 1;
        end
        secs.push_back(capture_hdr(frc_pkg::SEC_END, frc_pkg::SEQ_W'(seq), len_field(rem)));
        n   = secs.size();
        pos = $urandom_range(0, n - 1);
        case ($urandom_range(0, 11))
            4: secs[pos].message_seq = secs[pos].message_seq ^
                                       frc_pkg::SEQ_W'($urandom_range(1, 65535));
            5: secs[pos].section = 3'($urandom_range(SEC_INVALID_LO, SEC_INVALID_HI));
            6: secs[pos].payload_length = frc_pkg::LEN_W'($urandom_range(0, 511));
            7: begin
                h             = IN_W'($urandom);
                h.read_failed = 1'b1;
                secs.insert(pos, h);
            end
            8: void'(secs.pop_back());
            9: begin
                // restart: a start with the expected sequence after a valid prefix
                k = $urandom_range(1, n - 1);
                for (int i = 0; i < k; i++) prefix.push_back(secs[i]);
                secs[0].message_seq = frc_pkg::SEQ_W'(k);
            end
            10: begin
                h             = IN_W'($urandom);
                h.read_failed = 1'b0;
                case ($urandom_range(0, 3))
                    0: h.message_kind = KIND_INFO;
                    1: h.message_kind = KIND_LOG;
                    2: h.message_kind = KIND_UNKNOWN;
                    default: begin
                        h.message_kind = frc_pkg::KIND_CAPTURE;
                        h.section      = frc_pkg::SEC_NONE;
                    end
                endcase
                secs.insert(pos, h);
            end
            default: ;
        endcase
        foreach (prefix[i]) headers_to_send.push_back(prefix[i]);
        foreach (secs[i]) headers_to_send.push_back(secs[i]);
    endtask

    task automatic queue_traffic(input int unsigned size, input int unsigned n_items);
        int unsigned       base, pick;
        frc_pkg::t_in_item h;
        base = headers_to_send.size();
        while (headers_to_send.size() - base < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_frame(size);
            end else if (pick < 85) begin
                // stray capture sections, as seen while hunting
                h = capture_hdr(3'($urandom_range(frc_pkg::SEC_START, SEC_INVALID_HI)),
                                ($urandom_range(0, 1) == 1) ? frc_pkg::SEQ_W'(0)
                                                             : frc_pkg::SEQ_W'($urandom),
                                frc_pkg::LEN_W'($urandom_range(0, 511)));
                headers_to_send.push_back(h);
            end else begin
                h = IN_W'($urandom);
                headers_to_send.push_back(h);
            end
        end
    endtask

    initial begin : stimulus
        logic [frc_pkg::SIZE_W-1:0] sizes[$];
        frc_pkg::t_in_item          h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero frame size: empty frame, start too large, any skipped byte
        write_frame_size('0);
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd0));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_END, 16'd1, 9'd0));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd1));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'd3, 9'd1));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd0));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'd1, 9'd511));
        wait_drained();

        write_frame_size(24'd600);
        h = '1;
        headers_to_send.push_back(h);
        h = capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd10);
        h.message_kind = KIND_INFO;
        headers_to_send.push_back(h);
        h.message_kind = KIND_LOG;
        headers_to_send.push_back(h);
        h.message_kind = KIND_UNKNOWN;
        headers_to_send.push_back(h);
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_NONE, 16'd0, 9'd10));
        headers_to_send.push_back(capture_hdr(SEC_INVALID_HI, 16'd0, 9'd10));
        // hunting byte count runs past twice the frame size
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'hFFFF, 9'd511));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'd0, 9'd496));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_END, 16'd5, 9'd300));
        // good frame with a restart in the middle
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd511));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'd1, 9'd100));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd2, 9'd50));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'd1, 9'd496));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_END, 16'd2, 9'd54));
        // short end, wrong sequence, overflow, invalid section, read failure
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd0));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_END, 16'd1, 9'd10));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd0));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'd5, 9'd0));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd300));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_BODY, 16'd1, 9'd400));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd0));
        headers_to_send.push_back(capture_hdr(SEC_INVALID_LO, 16'd1, 9'd0));
        headers_to_send.push_back(capture_hdr(frc_pkg::SEC_START, 16'd0, 9'd10));
        h = '0;
        h.read_failed = 1'b1;
        headers_to_send.push_back(h);
        wait_drained();

        sizes = '{24'd1, 24'd495, 24'd496, 24'd497, 24'd1500, 24'd4000, 24'hFFFFFF, 24'd0,
                  frc_pkg::SIZE_W'($urandom_range(2, 3000)), frc_pkg::SIZE_W'($urandom)};
        foreach (sizes[i]) begin
            write_frame_size(sizes[i]);
            quiet = (i == 5);
            queue_traffic(sizes[i], 105);
            wait_drained();
        end
        quiet = 1'b0;

        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
